/* rtl/nsrl_pkg.sv */
// Shared constants, field types and command codes for the nearest-seed labeler.
`default_nettype none

package nsrl_pkg;

    // Sizing of the seed store and of the coordinate and label fields.
    localparam int MAX_SEEDS  = 64;
    localparam int COORD_BITS = 16;
    localparam int LABEL_BITS = 8;

    localparam int SLOT_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;
    localparam int SEED_W = LABEL_BITS + 2 * COORD_BITS;

    // Fixed widths of the stream and configuration ports.
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_W      = 7;

    // Request kinds carried on the input tuser bit.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One stored seed, x in the lowest bits.
    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } nsrl_seed_t;

    // Side information that travels with each candidate through the distance unit.
    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [LABEL_BITS-1:0] label;
        logic                  first;
        logic                  last;
    } nsrl_tag_t;

endpackage

`default_nettype wire

/* rtl/nsrl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nsrl_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output      logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/nsrl_dist_unit.sv */
// Two-stage squared-distance unit shared by every candidate seed of a query.
`default_nettype none

module nsrl_dist_unit
    import nsrl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic [COORD_BITS-1:0] px,
    input  wire logic [COORD_BITS-1:0] py,
    input  wire logic [COORD_BITS-1:0] sx,
    input  wire logic [COORD_BITS-1:0] sy,
    input  wire nsrl_tag_t             in_tag,
    output      logic                  out_valid,
    output      logic [DIST_W-1:0]     out_dist,
    output      nsrl_tag_t             out_tag
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_W-1:0]       sq_x_reg;
    logic [SQ_W-1:0]       sq_y_reg;
    logic                  sq_valid_reg;
    nsrl_tag_t             sq_tag_reg;
    logic                  dist_valid_reg;
    logic [DIST_W-1:0]     dist_reg;
    nsrl_tag_t             dist_tag_reg;

    // Absolute coordinate differences.
    always_comb begin
        dx = (px >= sx) ? (px - sx) : (sx - px);
        dy = (py >= sy) ? (py - sy) : (sy - py);
    end

    // Valid flags of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg   <= in_valid;
            dist_valid_reg <= sq_valid_reg;
        end
    end

    // Stage one squares the differences, stage two adds the squares.
    always_ff @(posedge aclk) begin
        sq_x_reg     <= SQ_W'(dx) * SQ_W'(dx);
        sq_y_reg     <= SQ_W'(dy) * SQ_W'(dy);
        sq_tag_reg   <= in_tag;
        dist_reg     <= DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg);
        dist_tag_reg <= sq_tag_reg;
    end

    assign out_valid = dist_valid_reg;
    assign out_dist  = dist_reg;
    assign out_tag   = dist_tag_reg;

endmodule

`default_nettype wire

/* rtl/nearest_seed_region_labeler_core.sv */
// Top level of the nearest-seed region labeler: request sequencer, seed store and argmin.
//
// Usage:
// A request enters on the s_ stream when s_tvalid and s_tready are both high; tuser
// selects a load (0) or a query (1). A load writes one seed slot and returns nothing.
// A query scans slots 0 to centroid_count-1, one slot per cycle through the seed
// RAM read port and the shared squared-distance unit, and returns the label, slot
// and squared distance of the nearest seed on the m_ stream; ties go to the lowest
// slot. A query passes through the scan, drain and push states; the result becomes
// valid in the same cycle that s_tready is high again. s_tready is low while a
// query runs. If the receiver stalls, the result waits in the output register;
// loads and a new query are still taken, and a finished query waits in its last
// state until the output register is free. centroid_count is to be written
// through cfg_we only while the block is idle; the block does not enforce this.
// 0 counts as 1 and values above 64 as 64. Reset sets centroid_count to 1 and
// empties the output; seed slots hold no value until loaded, and every slot
// searched must have been loaded first.
`default_nettype none

module nearest_seed_region_labeler_core
    import nsrl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration: centroid_count.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // Requests. tdata: slot[5:0], x_coord[21:6], y_coord[37:22], region_label[45:38].
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: command[0].
    input  wire logic [0:0]            s_tuser,
    // Results. tdata: label_out[7:0], nearest_slot[13:8], squared_distance[46:14].
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    state_t                  state_reg,     state_next;
    logic [CFG_W-1:0]        cfg_count_reg, cfg_count_next;
    logic [SLOT_W-1:0]       rd_addr_reg,   rd_addr_next;
    logic [SLOT_W-1:0]       count_m1_reg,  count_m1_next;
    logic                    m_tvalid_reg,  m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg,   m_tdata_next;
    logic [COORD_BITS-1:0]   px_reg,        px_next;
    logic [COORD_BITS-1:0]   py_reg,        py_next;
    logic                    s1_valid_reg,  s1_valid_next;
    logic [SLOT_W-1:0]       s1_slot_reg,   s1_slot_next;
    logic                    s1_last_reg,   s1_last_next;
    logic [DIST_W-1:0]       best_dist_reg, best_dist_next;
    logic [SLOT_W-1:0]       best_slot_reg, best_slot_next;
    logic [LABEL_BITS-1:0]   best_label_reg, best_label_next;

    logic                    accept;
    logic                    is_query;
    logic [5:0]              in_slot;
    nsrl_seed_t              in_seed;
    logic                    ram_we;
    logic                    rd_en;
    logic                    rd_last;
    nsrl_seed_t              ram_rdata;
    nsrl_tag_t               cand_tag;
    logic                    dq_valid;
    logic [DIST_W-1:0]       dq_dist;
    nsrl_tag_t               dq_tag;
    logic                    take_best;

    // Request decode.
    assign accept   = s_tvalid && s_tready;
    assign is_query = (s_tuser[0] == CMD_QUERY);
    assign in_slot  = s_tdata[5:0];
    always_comb begin
        in_seed.x     = COORD_BITS'(s_tdata[21:6]);
        in_seed.y     = COORD_BITS'(s_tdata[37:22]);
        in_seed.label = LABEL_BITS'(s_tdata[45:38]);
    end
    assign ram_we = accept && (s_tuser[0] == CMD_LOAD) && (32'(in_slot) < MAX_SEEDS);

    // Read issue while scanning.
    assign rd_en   = (state_reg == ST_SCAN);
    assign rd_last = (rd_addr_reg == count_m1_reg);

    nsrl_ram #(
        .WIDTH (SEED_W),
        .DEPTH (MAX_SEEDS)
    ) u_seed_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (SLOT_W'(in_slot)),
        .wdata (in_seed),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Candidate tag built once the seed word comes out of the RAM.
    always_comb begin
        cand_tag.slot  = s1_slot_reg;
        cand_tag.label = ram_rdata.label;
        cand_tag.first = (s1_slot_reg == '0);
        cand_tag.last  = s1_last_reg;
    end

    nsrl_dist_unit u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .px        (px_reg),
        .py        (py_reg),
        .sx        (ram_rdata.x),
        .sy        (ram_rdata.y),
        .in_tag    (cand_tag),
        .out_valid (dq_valid),
        .out_dist  (dq_dist),
        .out_tag   (dq_tag)
    );

    // Running minimum: strict compare keeps the lowest slot on ties.
    assign take_best = dq_valid && (dq_tag.first || (dq_dist < best_dist_reg));

    // Sequencer next-state logic.
    always_comb begin
        state_next      = state_reg;
        cfg_count_next  = cfg_count_reg;
        rd_addr_next    = rd_addr_reg;
        count_m1_next   = count_m1_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        s1_valid_next   = rd_en;
        s1_slot_next    = rd_addr_reg;
        s1_last_next    = rd_last;
        best_dist_next  = best_dist_reg;
        best_slot_next  = best_slot_reg;
        best_label_next = best_label_reg;

        if (cfg_we) begin
            cfg_count_next = cfg_wdata;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (take_best) begin
            best_dist_next  = dq_dist;
            best_slot_next  = dq_tag.slot;
            best_label_next = dq_tag.label;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_query) begin
                    px_next      = in_seed.x;
                    py_next      = in_seed.y;
                    rd_addr_next = '0;
                    if (cfg_count_reg == '0) begin
                        count_m1_next = '0;
                    end else if (32'(cfg_count_reg) > MAX_SEEDS) begin
                        count_m1_next = SLOT_W'(MAX_SEEDS - 1);
                    end else begin
                        count_m1_next = SLOT_W'(cfg_count_reg - CFG_W'(1));
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_addr_next = rd_addr_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (dq_valid && dq_tag.last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, 33'(best_dist_reg), 6'(best_slot_reg),
                                     8'(best_label_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and registered outputs; payload registers take no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= CFG_W'(1);
            m_tvalid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cfg_count_reg <= cfg_count_next;
            m_tvalid_reg  <= m_tvalid_next;
            s1_valid_reg  <= s1_valid_next;
        end
        rd_addr_reg    <= rd_addr_next;
        count_m1_reg   <= count_m1_next;
        m_tdata_reg    <= m_tdata_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        s1_slot_reg    <= s1_slot_next;
        s1_last_reg    <= s1_last_next;
        best_dist_reg  <= best_dist_next;
        best_slot_reg  <= best_slot_next;
        best_label_reg <= best_label_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Seed writes happen only while no candidate is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (!s1_valid_reg && !dq_valid))
        else $error("seed store written during a scan");

    // The scan never reads past the last slot in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_addr_reg <= count_m1_reg))
        else $error("scan address beyond slot count");

    // The last candidate reaches the minimum stage only after the scan has ended.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dq_valid && dq_tag.last) |-> (state_reg == ST_DRAIN))
        else $error("last candidate outside drain");

    // A new result appears only after a finished query.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_PUSH))
        else $error("result raised without a finished query");

endmodule

`default_nettype wire
